>>> rtl/dcdow_pkg.sv
// Shared types, constants and functions for the date check and day-of-week block.
// Used by dcdow_ctrl, dcdow_datapath and date_check_and_day_of_week.
package dcdow_pkg;

    localparam logic [13:0] EPOCH_YEAR = 14'd1589;
    localparam logic [13:0] MAX_YEAR   = 14'd9999;

    // Residues of the epoch year modulo 4, 100 and 400.
    localparam logic [1:0] EPOCH_MOD4   = 2'd1;
    localparam logic [6:0] EPOCH_MOD100 = 7'd89;
    localparam logic [8:0] EPOCH_MOD400 = 9'd389;

    localparam logic [6:0] LAST_MOD100 = 7'd99;
    localparam logic [8:0] LAST_MOD400 = 9'd399;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pre_ok;
        logic year_done;
        logic month_done;
        logic out_free;
    } dp_status_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Residue modulo 7 of a six-bit value below 63: eight is one modulo seven.
    function automatic logic [2:0] mod7(input logic [5:0] v);
        logic [3:0] fold;
        logic [3:0] red;
        fold = {1'b0, v[5:3]} + {1'b0, v[2:0]};
        red  = (fold >= 4'd7) ? (fold - 4'd7) : fold;
        return red[2:0];
    endfunction

endpackage

>>> rtl/date_check_and_day_of_week.sv
// Flow: a date with year 1590 to 9999, month 1 to 12 and a non-zero day is loaded; the year
// counter steps one year per cycle from 1589 to it, then the month counter one month per cycle
// from January to it, and the result is stored once the output register is free; any other
// item skips the counting. One item at a time: s_ready is high only in idle.
// Reset: aresetn is synchronous and active low; it clears the controller and the output valid.
// Top level: joins dcdow_ctrl and dcdow_datapath; depends on dcdow_pkg.
module date_check_and_day_of_week (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_day,
    input  logic [3:0]  s_month,
    input  logic [13:0] s_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [2:0]  m_weekday,
    output logic [2:0]  m_first_weekday,
    output logic [4:0]  m_month_length
);

    dcdow_pkg::ctrl_cmd_t  cmd;
    dcdow_pkg::dp_status_t status;

    dcdow_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dcdow_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_day           (s_day),
        .s_month         (s_month),
        .s_year          (s_year),
        .cmd             (cmd),
        .status          (status),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_valid_res     (m_valid_res),
        .m_weekday       (m_weekday),
        .m_first_weekday (m_first_weekday),
        .m_month_length  (m_month_length)
    );

endmodule

>>> rtl/dcdow_ctrl.sv
// Controller state machine: sequences load, year count, month count and result store.
// Depends on dcdow_pkg for the command and status structs.
module dcdow_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dcdow_pkg::dp_status_t status,
    output dcdow_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_YEARS  = 4'b0010,
        ST_MONTHS = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_YEARS;
                end
            end
            ST_YEARS: begin
                if (!status.pre_ok) begin
                    state_next = ST_FINISH;
                end else if (status.year_done) begin
                    state_next = ST_MONTHS;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTHS: begin
                if (status.month_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/dcdow_datapath.sv
// Datapath: input registers, year and month counters with weekday accumulator, result register.
// Depends on dcdow_pkg for constants, structs and the month length and modulo functions.
module dcdow_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [4:0]            s_day,
    input  logic [3:0]            s_month,
    input  logic [13:0]           s_year,
    input  dcdow_pkg::ctrl_cmd_t  cmd,
    output dcdow_pkg::dp_status_t status,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic                  m_valid_res,
    output logic [2:0]            m_weekday,
    output logic [2:0]            m_first_weekday,
    output logic [4:0]            m_month_length
);

    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [13:0] year_reg;
    logic [13:0] year_cnt_reg;
    logic [1:0]  mod4_reg;
    logic [6:0]  mod100_reg;
    logic [8:0]  mod400_reg;
    logic [3:0]  month_cnt_reg;
    logic [2:0]  acc_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        valid_res_reg;
    logic [2:0]  weekday_reg;
    logic [2:0]  first_reg;
    logic [4:0]  len_reg;

    logic        leap;
    logic        pre_ok;
    logic [4:0]  cur_len;
    logic [4:0]  step_len;
    logic [4:0]  step_inc;
    logic [5:0]  acc_sum;
    logic [4:0]  tgt_len;
    logic        date_ok;
    logic [5:0]  wd_sum;

    assign leap = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));

    assign pre_ok = (month_reg inside {[dcdow_pkg::MONTH_JAN:dcdow_pkg::MONTH_DEC]})
                    && (day_reg != 5'd0)
                    && (year_reg > dcdow_pkg::EPOCH_YEAR)
                    && (year_reg <= dcdow_pkg::MAX_YEAR);

    assign cur_len  = dcdow_pkg::month_len(month_cnt_reg, leap);
    assign step_len = cmd.month_step ? cur_len : (leap ? 5'd30 : 5'd29);
    assign step_inc = step_len - 5'd28;
    assign acc_sum  = {3'b000, acc_reg} + {3'b000, step_inc[2:0]};

    assign tgt_len = dcdow_pkg::month_len(month_reg, leap);
    assign date_ok = pre_ok && (day_reg <= tgt_len);
    assign wd_sum  = {3'b000, acc_reg} + {1'b0, day_reg} - 6'd1;

    assign status.pre_ok     = pre_ok;
    assign status.year_done  = (year_cnt_reg == year_reg);
    assign status.month_done = (month_cnt_reg == month_reg);
    assign status.out_free   = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            day_reg       <= s_day;
            month_reg     <= s_month;
            year_reg      <= s_year;
            year_cnt_reg  <= dcdow_pkg::EPOCH_YEAR;
            mod4_reg      <= dcdow_pkg::EPOCH_MOD4;
            mod100_reg    <= dcdow_pkg::EPOCH_MOD100;
            mod400_reg    <= dcdow_pkg::EPOCH_MOD400;
            month_cnt_reg <= dcdow_pkg::MONTH_JAN;
            acc_reg       <= 3'd0;
        end else if (cmd.year_step) begin
            year_cnt_reg <= year_cnt_reg + 14'd1;
            mod4_reg     <= mod4_reg + 2'd1;
            mod100_reg   <= (mod100_reg == dcdow_pkg::LAST_MOD100) ? 7'd0 : mod100_reg + 7'd1;
            mod400_reg   <= (mod400_reg == dcdow_pkg::LAST_MOD400) ? 9'd0 : mod400_reg + 9'd1;
            acc_reg      <= dcdow_pkg::mod7(acc_sum);
        end else if (cmd.month_step) begin
            month_cnt_reg <= month_cnt_reg + 4'd1;
            acc_reg       <= dcdow_pkg::mod7(acc_sum);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            valid_res_reg <= date_ok;
            weekday_reg   <= date_ok ? dcdow_pkg::mod7(wd_sum) : 3'd0;
            first_reg     <= date_ok ? acc_reg : 3'd0;
            len_reg       <= date_ok ? tgt_len : 5'd0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_valid_res     = valid_res_reg;
    assign m_weekday       = weekday_reg;
    assign m_first_weekday = first_reg;
    assign m_month_length  = len_reg;

`ifndef SYNTHESIS
    a_finish_needs_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_ready))
        else $error("Result stored while the output register still held an untaken result.");

    a_finish_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid_reg)
        else $error("Stored result was not presented.");

    a_invalid_gives_zeros: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !valid_res_reg) |->
            (weekday_reg == 3'd0 && first_reg == 3'd0 && len_reg == 5'd0))
        else $error("Invalid date carried non-zero result fields.");

    a_no_year_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.year_step |-> (year_cnt_reg != year_reg))
        else $error("Year counter stepped past the requested year.");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && valid_res_reg) |-> (weekday_reg < 3'd7 && first_reg < 3'd7))
        else $error("Weekday out of range on a valid date.");
`endif

endmodule
